[rtl/core/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned ID_W   = 22;
   localparam int unsigned PRIO_W = 16;

   localparam logic CMD_SUBSCRIBE = 1'b0;
   localparam logic CMD_REMOVE    = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // Request from the sequencer to the task table.
   typedef struct packed {
      logic              append;
      logic              remove;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } tbl_cmd_type;

   // Status from the task table back to the sequencer.
   typedef struct packed {
      logic              full;
      logic              done;
      logic              best_valid;
      logic [ID_W-1:0]   best_id;
      logic [PRIO_W-1:0] best_prio;
   } tbl_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage

[rtl/core/pps_table.sv]
// Task table: entry memory, fill count, and the remove/compact/rescan walk.
module pps_table (
   input  logic                 clock,
   input  logic                 reset,
   input  pps_pkg::tbl_cmd_type tbl_cmd,
   output pps_pkg::tbl_sts_type tbl_sts
);

   pps_pkg::entry_type mem [pps_pkg::DEPTH];

   logic [pps_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       walking_ff, walking_in;
   logic [pps_pkg::CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic                       pend_ff, pend_in;
   logic [pps_pkg::IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic                       found_ff, found_in;
   logic                       best_vld_ff, best_vld_in;
   pps_pkg::entry_type         best_ff, best_in;
   logic [pps_pkg::ID_W-1:0]   key_ff, key_in;
   pps_pkg::entry_type         rd_data_ff;

   logic                       full;
   logic                       issue;
   logic                       done;
   logic                       wr_en;
   logic [pps_pkg::IDX_W-1:0]  wr_addr;
   pps_pkg::entry_type         wr_data;

   assign full  = (count_ff >= pps_pkg::CNT_W'(pps_pkg::DEPTH));
   assign issue = walking_ff && (rd_ptr_ff < count_ff);
   assign done  = walking_ff && !issue && !pend_ff;

   always_comb begin
      count_in    = count_ff;
      walking_in  = walking_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_in     = issue;
      pend_idx_in = rd_ptr_ff[pps_pkg::IDX_W-1:0];
      found_in    = found_ff;
      best_vld_in = best_vld_ff;
      best_in     = best_ff;
      key_in      = key_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[pps_pkg::IDX_W-1:0];
      wr_data     = '{id: tbl_cmd.id, prio: tbl_cmd.prio};

      if (tbl_cmd.append && !full) begin
         wr_en    = 1'b1;
         count_in = count_ff + pps_pkg::CNT_W'(1);
      end

      if (tbl_cmd.remove) begin
         walking_in  = 1'b1;
         rd_ptr_in   = '0;
         found_in    = 1'b0;
         best_vld_in = 1'b0;
         key_in      = tbl_cmd.id;
      end

      if (issue) begin
         rd_ptr_in = rd_ptr_ff + pps_pkg::CNT_W'(1);
      end

      // Drop the first match; shift every later row down one and track the best.
      if (pend_ff) begin
         if (!found_ff && (rd_data_ff.id == key_ff)) begin
            found_in = 1'b1;
         end else begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - pps_pkg::IDX_W'(1);
               wr_data = rd_data_ff;
            end
            if (!best_vld_ff || (rd_data_ff.prio > best_ff.prio)) begin
               best_vld_in = 1'b1;
               best_in     = rd_data_ff;
            end
         end
      end

      if (done) begin
         walking_in = 1'b0;
         count_in   = count_ff - pps_pkg::CNT_W'(found_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         walking_ff  <= 1'b0;
         pend_ff     <= 1'b0;
         found_ff    <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         walking_ff  <= walking_in;
         pend_ff     <= pend_in;
         found_ff    <= found_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      pend_idx_ff <= pend_idx_in;
      best_ff     <= best_in;
      key_ff      <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_ptr_ff[pps_pkg::IDX_W-1:0]];
   end

   assign tbl_sts.full       = full;
   assign tbl_sts.done       = done;
   assign tbl_sts.best_valid = best_vld_ff;
   assign tbl_sts.best_id    = best_ff.id;
   assign tbl_sts.best_prio  = best_ff.prio;

endmodule

[rtl/core/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler.
// Subscribe: result strobe in the cycle after the one that accepts the command; busy stays low.
// Remove: busy while the table walk runs over the N entries held (at most 16);
//    the walk reads one table row per cycle through a single registered read port.
// Exactly one result word per command; the receiver cannot stall.
// Reset (synchronous, active high) empties the table and clears top and running task.
module preemptive_priority_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [pps_pkg::ID_W-1:0]    req_task_id,
   input  logic [pps_pkg::PRIO_W-1:0]  req_task_priority,
   output logic                        rsp_valid,
   output logic                        rsp_switched,
   output logic                        rsp_stop_valid,
   output logic [pps_pkg::ID_W-1:0]    rsp_stopped_id,
   output logic [pps_pkg::ID_W-1:0]    rsp_started_id,
   output logic                        rsp_top_valid,
   output logic [pps_pkg::PRIO_W-1:0]  rsp_top_priority,
   output logic                        rsp_dropped
);

   pps_pkg::state_type          state_ff, state_in;
   pps_pkg::tbl_cmd_type        tbl_cmd;
   pps_pkg::tbl_sts_type        tbl_sts;

   // Current top task and running task.
   logic                        top_vld_ff, top_vld_in;
   logic [pps_pkg::ID_W-1:0]    top_id_ff, top_id_in;
   logic [pps_pkg::PRIO_W-1:0]  top_prio_ff, top_prio_in;
   logic                        run_vld_ff, run_vld_in;
   logic [pps_pkg::ID_W-1:0]    run_id_ff, run_id_in;

   // Result word registers.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        sw_ff, sw_in;
   logic                        stop_ff, stop_in;
   logic [pps_pkg::ID_W-1:0]    stopped_ff, stopped_in;
   logic [pps_pkg::ID_W-1:0]    started_ff, started_in;
   logic                        topv_ff;
   logic [pps_pkg::PRIO_W-1:0]  topp_ff, topp_in;
   logic                        drop_ff, drop_in;

   logic                        accept;
   logic                        commit;

   assign busy   = (state_ff == pps_pkg::ST_WALK);
   assign accept = start && !busy;

   pps_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_cmd (tbl_cmd),
      .tbl_sts (tbl_sts)
   );

   always_comb begin
      state_in     = state_ff;
      tbl_cmd      = '{append: 1'b0, remove: 1'b0, id: req_task_id, prio: req_task_priority};
      top_vld_in   = top_vld_ff;
      top_id_in    = top_id_ff;
      top_prio_in  = top_prio_ff;
      drop_in      = 1'b0;
      commit       = 1'b0;

      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == pps_pkg::CMD_SUBSCRIBE) begin
                  // Append; take over the top when there is none or on a strictly greater priority.
                  tbl_cmd.append = 1'b1;
                  commit         = 1'b1;
                  if (tbl_sts.full) begin
                     drop_in = 1'b1;
                  end else if (!top_vld_ff || (req_task_priority > top_prio_ff)) begin
                     top_vld_in  = 1'b1;
                     top_id_in   = req_task_id;
                     top_prio_in = req_task_priority;
                  end
               end else begin
                  // Remove: hand off to the table walk.
                  tbl_cmd.remove = 1'b1;
                  state_in       = pps_pkg::ST_WALK;
               end
            end
         end
         pps_pkg::ST_WALK: begin
            if (tbl_sts.done) begin
               // Adopt the rescan result; an empty table clears the top.
               commit      = 1'b1;
               state_in    = pps_pkg::ST_IDLE;
               top_vld_in  = tbl_sts.best_valid;
               top_id_in   = tbl_sts.best_valid ? tbl_sts.best_id : '0;
               top_prio_in = tbl_sts.best_valid ? tbl_sts.best_prio : '0;
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   // Schedule check on the new top; an empty table leaves the running task alone.
   always_comb begin
      run_vld_in   = run_vld_ff;
      run_id_in    = run_id_ff;
      rsp_valid_in = commit;
      sw_in        = 1'b0;
      stop_in      = 1'b0;
      stopped_in   = '0;
      started_in   = '0;
      topp_in      = top_vld_in ? top_prio_in : '0;

      if (commit && top_vld_in && (!run_vld_ff || (top_id_in != run_id_ff))) begin
         sw_in      = 1'b1;
         started_in = top_id_in;
         if (run_vld_ff) begin
            stop_in    = 1'b1;
            stopped_in = run_id_ff;
         end
         run_vld_in = 1'b1;
         run_id_in  = top_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_IDLE;
         top_vld_ff   <= 1'b0;
         top_id_ff    <= '0;
         top_prio_ff  <= '0;
         run_vld_ff   <= 1'b0;
         run_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_vld_ff   <= top_vld_in;
         top_id_ff    <= top_id_in;
         top_prio_ff  <= top_prio_in;
         run_vld_ff   <= run_vld_in;
         run_id_ff    <= run_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result word between commits.
   always_ff @(posedge clock) begin
      if (commit) begin
         sw_ff      <= sw_in;
         stop_ff    <= stop_in;
         stopped_ff <= stopped_in;
         started_ff <= started_in;
         topv_ff    <= top_vld_in;
         topp_ff    <= topp_in;
         drop_ff    <= drop_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_switched     = sw_ff;
   assign rsp_stop_valid   = stop_ff;
   assign rsp_stopped_id   = stopped_ff;
   assign rsp_started_id   = started_ff;
   assign rsp_top_valid    = topv_ff;
   assign rsp_top_priority = topp_ff;
   assign rsp_dropped      = drop_ff;

endmodule

[rtl/core/pps_checker.sv]
// Port-level checker for the preemptive priority scheduler, bound to the top level.
module pps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_cmd,
   input logic                        rsp_valid,
   input logic                        rsp_switched,
   input logic                        rsp_stop_valid,
   input logic [pps_pkg::ID_W-1:0]    rsp_stopped_id,
   input logic [pps_pkg::ID_W-1:0]    rsp_started_id,
   input logic                        rsp_top_valid,
   input logic [pps_pkg::PRIO_W-1:0]  rsp_top_priority
);

   // A subscribe answers on the next cycle.
   a_sub_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == pps_pkg::CMD_SUBSCRIBE)) |=> rsp_valid)
      else $error("subscribe without result word");

   // The end of a remove walk delivers its result word.
   a_walk_answer: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("remove finished without result word");

   // A stop always pairs with a start of a different task.
   a_stop_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_valid) |-> (rsp_switched && (rsp_stopped_id != rsp_started_id)))
      else $error("stop without matching start");

   // No switch without a top task; an empty table reports zero priority.
   a_empty_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_top_valid) |-> (!rsp_switched && (rsp_top_priority == '0)))
      else $error("switch or priority reported with empty table");

   // Without a switch, no ids are reported.
   a_no_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_switched) |-> (!rsp_stop_valid && (rsp_started_id == '0)))
      else $error("ids reported without a switch");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
